/* src/par_pkg.sv */
// Shared types and constants for the per-axis position ramp.
// No dependencies; used by par_ramp_calc and the top level.
package par_pkg;

	localparam int unsigned POS_W  = 32;
	localparam int unsigned STEP_W = 31;
	localparam int unsigned SEL_W  = 5;
	localparam int unsigned IDX_W  = 6;
	localparam int unsigned SW_W   = 16;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_MODE_ON  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SEL_AXIS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GOAL     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP     = 2'd3;

	localparam logic [STEP_W-1:0] STEP_RESET = 31'd100;

	// CiA402 "operation enabled" state in the status word.
	localparam logic [SW_W-1:0] SW_STATE_MASK = 16'h006F;
	localparam logic [SW_W-1:0] SW_OP_ENABLED = 16'h0027;

	typedef logic signed [POS_W-1:0] pos_t;

	typedef struct packed {
		logic ramp;       // selected axis with operation enabled
		logic fwd;        // entry was written as this word was read
		logic ent_valid;  // entry has been written since reset
	} ramp_ctl_t;

endpackage

/* src/par_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module par_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 32
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* src/par_ramp_calc.sv */
// Ramp datapath: picks the current value, steps it to goal or passes actual.
// Depends on par_pkg.
module par_ramp_calc (
	input  par_pkg::ramp_ctl_t           ctl,
	input  par_pkg::pos_t                rd_data,
	input  par_pkg::pos_t                fwd_data,
	input  par_pkg::pos_t                actual,
	input  par_pkg::pos_t                goal,
	input  logic [par_pkg::STEP_W-1:0]   step,
	output par_pkg::pos_t                new_pos
);

	import par_pkg::*;

	pos_t              cur;
	logic signed [POS_W:0] diff;
	logic signed [POS_W:0] step_pos;
	logic signed [POS_W:0] step_neg;
	logic              in_reach;
	pos_t              stepped;

	always_comb begin
		if (ctl.fwd) begin
			cur = fwd_data;
		end else if (ctl.ent_valid) begin
			cur = rd_data;
		end else begin
			cur = '0;
		end
		// Full-width difference so it never wraps.
		diff     = {goal[POS_W-1], goal} - {cur[POS_W-1], cur};
		step_pos = $signed({2'b00, step});
		step_neg = -step_pos;
		in_reach = (diff <= step_pos) && (diff >= step_neg);
		if (diff[POS_W]) begin
			stepped = cur - $signed({1'b0, step});
		end else begin
			stepped = cur + $signed({1'b0, step});
		end
		if (!ctl.ramp) begin
			new_pos = actual;
		end else if (in_reach) begin
			new_pos = goal;
		end else begin
			new_pos = stepped;
		end
	end

endmodule

/* src/per_axis_position_ramp_unit.sv */
// Top level of the per-axis position ramp: config registers, table pipeline.
// Depends on par_pkg, par_ram and par_ramp_calc.
//
// Usage: each input word on the in channel is one cyclic exchange of one drive
// axis (axis_index, actual_position, drive_status). Registers sit on the cfg
// channel (index 0 mode, 1 selected axis, 2 goal, 3 step size); the user must
// write them only while the block is idle, as the block does not enforce it;
// cfg_ready is always high. With position mode off, or an axis index of AXES
// or more, the word is taken and produces no result. Otherwise one
// target_position word appears on the out channel after it has passed through
// the ramp stage and the output register. Throughput is one word per clock
// while the receiver keeps up: the table entry is read from the RAM at
// acceptance and written back as the word leaves the ramp stage, and a bypass
// register covers a word that reads the entry being written in the same cycle.
// When the receiver stalls, the output register holds its word and the ramp
// stage holds one more; in_ready drops only when both are full.
// Reset clears the control registers and the per-entry valid flags, so every
// table entry reads as zero right after reset without any clearing pass.
module per_axis_position_ramp_unit #(
	parameter int unsigned AXES = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [par_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [par_pkg::POS_W-1:0]      cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [par_pkg::IDX_W-1:0]      axis_index,
	input  par_pkg::pos_t                  actual_position,
	input  logic [par_pkg::SW_W-1:0]       drive_status,
	output logic                           out_valid,
	input  logic                           out_ready,
	output par_pkg::pos_t                  target_position
);

	import par_pkg::*;

	localparam int unsigned AW = (AXES > 1) ? $clog2(AXES) : 1;

	// Configuration registers.
	logic              mode_on_q;
	logic [SEL_W-1:0]  sel_axis_q;
	pos_t              goal_q;
	logic [STEP_W-1:0] step_q;

	// Ramp stage.
	logic              s1_valid_q;
	logic [AW-1:0]     idx_s1;
	pos_t              actual_s1;
	ramp_ctl_t         ctl_s1;
	pos_t              fwd_data_s1;

	logic              out_valid_q;
	pos_t              target_q;
	logic [AXES-1:0]   ent_valid_q;

	logic              in_acc;
	logic              in_range;
	logic              in_take;
	logic              advance;
	logic [AW-1:0]     in_addr;
	logic              op_en;
	logic              is_sel;
	pos_t              rd_data;
	pos_t              new_pos;

	assign cfg_ready = 1'b1;
	assign in_range  = ({1'b0, axis_index} < (IDX_W + 1)'(AXES));
	assign in_addr   = axis_index[AW-1:0];
	assign op_en     = ((drive_status & SW_STATE_MASK) == SW_OP_ENABLED);
	assign is_sel    = (axis_index == {1'b0, sel_axis_q});
	assign advance   = s1_valid_q && (!out_valid_q || out_ready);
	assign in_ready  = !s1_valid_q || advance;
	assign in_acc    = in_valid && in_ready;
	assign in_take   = in_acc && mode_on_q && in_range;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_on_q  <= 1'b0;
			sel_axis_q <= '0;
			goal_q     <= '0;
			step_q     <= STEP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MODE_ON:  mode_on_q  <= cfg_data[0];
				CFG_SEL_AXIS: sel_axis_q <= cfg_data[SEL_W-1:0];
				CFG_GOAL:     goal_q     <= cfg_data;
				CFG_STEP:     step_q     <= cfg_data[STEP_W-1:0];
				default:      ;
			endcase
		end
	end

	par_ram #(
		.WIDTH(POS_W),
		.DEPTH(AXES)
	) u_table (
		.clk   (clk),
		.we    (advance),
		.waddr (idx_s1),
		.wdata (new_pos),
		.re    (in_take),
		.raddr (in_addr),
		.rdata (rd_data)
	);

	par_ramp_calc u_calc (
		.ctl      (ctl_s1),
		.rd_data  (rd_data),
		.fwd_data (fwd_data_s1),
		.actual   (actual_s1),
		.goal     (goal_q),
		.step     (step_q),
		.new_pos  (new_pos)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
			ent_valid_q <= '0;
			ctl_s1      <= '0;
		end else begin
			if (in_take) begin
				s1_valid_q <= 1'b1;
			end else if (advance) begin
				s1_valid_q <= 1'b0;
			end
			if (advance) begin
				out_valid_q         <= 1'b1;
				ent_valid_q[idx_s1] <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (in_take) begin
				ctl_s1.ramp      <= is_sel && op_en;
				ctl_s1.fwd       <= advance && (idx_s1 == in_addr);
				ctl_s1.ent_valid <= ent_valid_q[in_addr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			idx_s1      <= in_addr;
			actual_s1   <= actual_position;
			fwd_data_s1 <= new_pos;
		end
		if (advance) begin
			target_q <= new_pos;
		end
	end

	assign out_valid       = out_valid_q;
	assign target_position = target_q;

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (s1_valid_q && out_valid_q && !out_ready))
		else $error("input stalled while the pipeline had room");

	a_take_fills_stage: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && mode_on_q && in_range) |=> s1_valid_q)
		else $error("accepted word did not enter the ramp stage");

	a_out_from_stage: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(s1_valid_q))
		else $error("result appeared without a word in the ramp stage");

endmodule
